### hdl/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types, constants and the control store of the table search engine.
// ----------------------------------------------------------------------------
package tse_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int ENTRY_WIDTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
    localparam int BND_W       = LEN_W + 1;

    // field widths fixed by the stream format
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 4;
    localparam int CFG_W   = 5;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BINARY = 2'd2;

    // control store addresses
    typedef logic [3:0] upc_t;
    localparam upc_t ST_IDLE     = 4'd0;
    localparam upc_t ST_LOAD     = 4'd1;
    localparam upc_t ST_LIN_INIT = 4'd2;
    localparam upc_t ST_LIN_LOOP = 4'd3;
    localparam upc_t ST_SWAP_A   = 4'd4;
    localparam upc_t ST_SWAP_B   = 4'd5;
    localparam upc_t ST_BIN_INIT = 4'd6;
    localparam upc_t ST_BIN_CHK  = 4'd7;
    localparam upc_t ST_BIN_CMP  = 4'd8;
    localparam upc_t ST_MISS     = 4'd9;
    localparam upc_t ST_BIN_HIT  = 4'd10;
    localparam upc_t ST_EMIT     = 4'd11;

    // branch conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_LIN_HIT,
        C_LIN_END,
        C_BIN_EMPTY,
        C_BIN_EQ,
        C_OUT_BUSY
    } cond_t;

    // datapath register operations
    typedef enum logic [2:0] {
        DP_NONE,
        DP_LIN_INIT,
        DP_LIN_STEP,
        DP_BIN_INIT,
        DP_BIN_PROBE,
        DP_BIN_UPD
    } dp_op_t;

    // table write operations
    typedef enum logic [1:0] {
        M_NONE,
        M_LOAD,
        M_SWAP_A,
        M_SWAP_B
    } mem_op_t;

    // result staging operations
    typedef enum logic [1:0] {
        R_NONE,
        R_HIT_CMP,
        R_HIT_MID,
        R_MISS
    } res_op_t;

    // one control word
    typedef struct packed {
        logic    dispatch;
        cond_t   cond_a;
        upc_t    tgt_a;
        cond_t   cond_b;
        upc_t    tgt_b;
        logic    stay;
        dp_op_t  dp_op;
        mem_op_t mem_op;
        res_op_t res_op;
        logic    emit;
    } ucode_t;

    // control store contents
    function automatic ucode_t ucode_rom(upc_t addr);
        ucode_t w;
        w = '0;
        case (addr)
            ST_IDLE:
            begin
                w.dispatch = 1'b1;
            end
            ST_LOAD:
            begin
                w.mem_op = M_LOAD;
                w.cond_a = C_ALWAYS;
                w.tgt_a  = ST_IDLE;
            end
            ST_LIN_INIT:
            begin
                w.dp_op = DP_LIN_INIT;
            end
            ST_LIN_LOOP:
            begin
                w.dp_op  = DP_LIN_STEP;
                w.cond_a = C_LIN_HIT;
                w.tgt_a  = ST_SWAP_A;
                w.cond_b = C_LIN_END;
                w.tgt_b  = ST_MISS;
                w.stay   = 1'b1;
            end
            ST_SWAP_A:
            begin
                w.mem_op = M_SWAP_A;
                w.res_op = R_HIT_CMP;
            end
            ST_SWAP_B:
            begin
                w.mem_op = M_SWAP_B;
                w.cond_a = C_ALWAYS;
                w.tgt_a  = ST_EMIT;
            end
            ST_BIN_INIT:
            begin
                w.dp_op = DP_BIN_INIT;
            end
            ST_BIN_CHK:
            begin
                w.dp_op  = DP_BIN_PROBE;
                w.cond_a = C_BIN_EMPTY;
                w.tgt_a  = ST_MISS;
            end
            ST_BIN_CMP:
            begin
                w.dp_op  = DP_BIN_UPD;
                w.cond_a = C_BIN_EQ;
                w.tgt_a  = ST_BIN_HIT;
                w.cond_b = C_ALWAYS;
                w.tgt_b  = ST_BIN_CHK;
            end
            ST_MISS:
            begin
                w.res_op = R_MISS;
                w.cond_a = C_ALWAYS;
                w.tgt_a  = ST_EMIT;
            end
            ST_BIN_HIT:
            begin
                w.res_op = R_HIT_MID;
            end
            ST_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond_a = C_OUT_BUSY;
                w.tgt_a  = ST_EMIT;
                w.cond_b = C_ALWAYS;
                w.tgt_b  = ST_IDLE;
            end
            default:
            begin
                w.cond_a = C_ALWAYS;
                w.tgt_a  = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // entry point of the routine for each item kind
    function automatic upc_t dispatch_target(logic [MODE_W-1:0] mode);
        upc_t t;
        case (mode)
            MODE_LOAD:   t = ST_LOAD;
            MODE_LINEAR: t = ST_LIN_INIT;
            MODE_BINARY: t = ST_BIN_INIT;
            default:     t = ST_IDLE;
        endcase
        return t;
    endfunction

endpackage

### hdl/table_search_engine.sv
// ----------------------------------------------------------------------------
// table_search_engine
// Signed table with entry loads, linear search that swaps a hit with entry 0
// and binary search, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_tready is high only while the sequencer
// waits at its idle step. A load passes through the load step and returns to
// idle; an unused mode stays at idle. A linear search runs the init step and
// then the scan loop, where the single table read port reads one entry per
// cycle; a miss then goes to the miss step, and a hit ends with two write
// steps (SWAP_A, SWAP_B) for the swap with entry 0. A binary search repeats
// a probe of a read step and a compare step, then ends in the hit or the miss
// step. The result sits in an output register, so the next item can be
// taken while it waits; a new result waits only if the previous one has not
// been taken. The table has no reset value and needs no clearing.
module table_search_engine (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write: table_length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [tse_pkg::CFG_W-1:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] entry_index, [35:4] key_value, [39:36] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] position, [7:4] zero
    output logic [0:0]  m_tuser    // [0] found
);
    import tse_pkg::*;

    // sequencer
    upc_t   upc_reg, upc_next;
    ucode_t uw;

    // item registers
    logic [INDEX_W-1:0]     idx_reg;
    logic [ENTRY_WIDTH-1:0] key_reg;
    logic [CFG_W-1:0]       len_reg;

    // datapath registers
    logic [LEN_W-1:0]         ptr_reg;
    logic [IDX_W-1:0]         cmp_ptr_reg;
    logic                     rd_vld_reg;
    logic [ENTRY_WIDTH-1:0]   front_reg;
    logic signed [BND_W-1:0]  lo_reg;
    logic signed [BND_W-1:0]  hi_reg;
    logic [IDX_W-1:0]         mid_reg;
    logic                     res_found_reg;
    logic [IDX_W-1:0]         res_pos_reg;
    logic                     m_tvalid_reg;
    logic                     out_found_reg;
    logic [IDX_W-1:0]         out_pos_reg;

    // table memory
    logic [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;
    logic                   wr_en;

    // derived values
    logic [LEN_W-1:0]        act_len;
    logic signed [BND_W-1:0] bnd_sum;
    logic [IDX_W-1:0]        mid_calc;
    logic                    s_xfer;
    logic                    out_busy;
    logic                    cond_a_ok;
    logic                    cond_b_ok;
    logic                    scan_more;
    logic                    lin_hit;

    assign uw        = ucode_rom(upc_reg);
    assign s_tready  = (upc_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_busy  = m_tvalid_reg && !m_tready;

    // clamp the configured length to the table depth
    assign act_len = (len_reg > CFG_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                     : LEN_W'(len_reg);
    assign scan_more = (ptr_reg < act_len);
    assign lin_hit   = rd_vld_reg && (rd_data_reg == key_reg);
    assign bnd_sum   = lo_reg + hi_reg;
    assign mid_calc  = bnd_sum[IDX_W:1];

    // condition evaluation
    function automatic logic cond_eval(cond_t c, logic lin_hit, logic lin_end,
                                       logic bin_empty, logic bin_eq, logic busy);
        logic r;
        case (c)
            C_NEVER:     r = 1'b0;
            C_ALWAYS:    r = 1'b1;
            C_LIN_HIT:   r = lin_hit;
            C_LIN_END:   r = lin_end;
            C_BIN_EMPTY: r = bin_empty;
            C_BIN_EQ:    r = bin_eq;
            C_OUT_BUSY:  r = busy;
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

    assign cond_a_ok = cond_eval(uw.cond_a, lin_hit,
                                 !scan_more, lo_reg > hi_reg,
                                 rd_data_reg == key_reg, out_busy);
    assign cond_b_ok = cond_eval(uw.cond_b, lin_hit,
                                 !scan_more, lo_reg > hi_reg,
                                 rd_data_reg == key_reg, out_busy);

    // next step address
    always_comb
    begin
        if (uw.dispatch)
        begin
            upc_next = s_xfer ? dispatch_target(s_tuser[MODE_W-1:0]) : ST_IDLE;
        end
        else if (cond_a_ok)
        begin
            upc_next = uw.tgt_a;
        end
        else if (cond_b_ok)
        begin
            upc_next = uw.tgt_b;
        end
        else if (uw.stay)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            len_reg <= cfg_data;
        end
    end

    // capture of the accepted item
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            idx_reg <= s_tdata[INDEX_W-1:0];
            key_reg <= s_tdata[INDEX_W +: ENTRY_WIDTH];
        end
    end

    // scan read valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (uw.dp_op == DP_LIN_INIT)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (uw.dp_op == DP_LIN_STEP)
        begin
            rd_vld_reg <= scan_more;
        end
    end

    // scan and bisection registers
    always_ff @(posedge clk)
    begin
        case (uw.dp_op)
            DP_LIN_INIT:
            begin
                ptr_reg <= '0;
            end
            DP_LIN_STEP:
            begin
                if (rd_vld_reg && (cmp_ptr_reg == '0))
                begin
                    front_reg <= rd_data_reg;
                end
                // hold the matching index for the swap
                if (scan_more && !lin_hit)
                begin
                    cmp_ptr_reg <= ptr_reg[IDX_W-1:0];
                    ptr_reg     <= ptr_reg + LEN_W'(1);
                end
            end
            DP_BIN_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= $signed({1'b0, act_len}) - BND_W'(1);
            end
            DP_BIN_PROBE:
            begin
                mid_reg <= mid_calc;
            end
            DP_BIN_UPD:
            begin
                if ($signed(key_reg) < $signed(rd_data_reg))
                begin
                    hi_reg <= $signed({{(BND_W-IDX_W){1'b0}}, mid_reg}) - BND_W'(1);
                end
                else
                begin
                    lo_reg <= $signed({{(BND_W-IDX_W){1'b0}}, mid_reg}) + BND_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // table port address and write selection
    always_comb
    begin
        rd_addr = (uw.dp_op == DP_BIN_PROBE) ? mid_calc : ptr_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = key_reg;
        case (uw.mem_op)
            M_LOAD:
            begin
                wr_en   = (32'(idx_reg) < TABLE_DEPTH);
                wr_addr = idx_reg[IDX_W-1:0];
            end
            M_SWAP_A:
            begin
                wr_en   = 1'b1;
                wr_addr = cmp_ptr_reg;
                wr_data = front_reg;
            end
            M_SWAP_B:
            begin
                wr_en   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // result staging
    always_ff @(posedge clk)
    begin
        case (uw.res_op)
            R_HIT_CMP:
            begin
                res_found_reg <= 1'b1;
                res_pos_reg   <= cmp_ptr_reg;
            end
            R_HIT_MID:
            begin
                res_found_reg <= 1'b1;
                res_pos_reg   <= mid_reg;
            end
            R_MISS:
            begin
                res_found_reg <= 1'b0;
                res_pos_reg   <= '0;
            end
            default:
            begin
            end
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (uw.emit && !out_busy)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (uw.emit && !out_busy)
        begin
            out_found_reg <= res_found_reg;
            out_pos_reg   <= res_pos_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8-IDX_W){1'b0}}, out_pos_reg};
    assign m_tuser  = out_found_reg;

    // a load transfer enters the load step
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && (s_tuser == MODE_LOAD)) |=> (upc_reg == ST_LOAD))
        else $error("load transfer did not start the load step");

    // a stalled result holds the sequencer at the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        ((upc_reg == ST_EMIT) && out_busy) |=> (upc_reg == ST_EMIT))
        else $error("emit step left while output was stalled");

    // a compared scan entry lies inside the searched range
    assert property (@(posedge clk) disable iff (!rst_n)
        ((upc_reg == ST_LIN_LOOP) && rd_vld_reg) |-> (LEN_W'(cmp_ptr_reg) < act_len))
        else $error("scan compared an entry outside the table length");

    // a bisection probe lies inside the searched range
    assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == ST_BIN_CMP) |-> (LEN_W'(mid_reg) < act_len))
        else $error("binary probe outside the table length");

    // a new result appears only from the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(upc_reg == ST_EMIT))
        else $error("result raised outside the emit step");

endmodule

### tb/search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_checker
// Watches the configuration, item and result channels of the table search
// engine, keeps its own copy of the table and of table_length, predicts the
// answer of every search and compares it with the results in order.
// ----------------------------------------------------------------------------
module search_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [tse_pkg::CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [39:0]      s_tdata,   // [3:0] entry_index, [35:4] key_value
    input  logic [1:0]       s_tuser,   // [1:0] mode
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [7:0]       m_tdata,   // [3:0] position
    input  logic [0:0]       m_tuser,   // [0] found
    output int               mismatch_count,
    output int               outstanding
);
    import tse_pkg::*;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   position;
    } search_result_t;

    // model state
    logic signed [ENTRY_WIDTH-1:0] entries [TABLE_DEPTH];
    logic [CFG_W-1:0]              length_copy;
    search_result_t                pending_results [$];
    search_result_t                want;
    int                            results_seen;

    // one line per mismatch, counted; printing stops after a while
    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
        begin
            $display("ERROR at %0t: result %0d: %s", $time, results_seen, what);
        end
        mismatch_count = mismatch_count + 1;
    endtask

    // lengths above the depth search the whole table
    function automatic int searched_length();
        if (length_copy > TABLE_DEPTH)
        begin
            return TABLE_DEPTH;
        end
        return int'(length_copy);
    endfunction

    // first equal entry from the front, moved to entry 0
    function automatic search_result_t scan_and_swap(input logic signed [ENTRY_WIDTH-1:0] key);
        search_result_t                r;
        logic signed [ENTRY_WIDTH-1:0] tmp;
        int                            n;
        bit                            done;
        r    = '0;
        done = 1'b0;
        n    = searched_length();
        for (int i = 0; i < n; i++)
        begin
            if (!done && entries[i] == key)
            begin
                tmp        = entries[i];
                entries[i] = entries[0];
                entries[0] = tmp;
                r.found    = 1'b1;
                r.position = i[IDX_W-1:0];
                done       = 1'b1;
            end
        end
        return r;
    endfunction

    // halving over the entries as they stand, signed order
    function automatic search_result_t halving_search(input logic signed [ENTRY_WIDTH-1:0] key);
        search_result_t r;
        int             lo;
        int             hi;
        int             mid;
        bit             done;
        r    = '0;
        done = 1'b0;
        lo   = 0;
        hi   = searched_length() - 1;
        while (!done && lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (entries[mid] == key)
            begin
                r.found    = 1'b1;
                r.position = mid[IDX_W-1:0];
                done       = 1'b1;
            end
            else if (key < entries[mid])
            begin
                hi = mid - 1;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        return r;
    endfunction

    // channel monitor and comparison
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                entries[i] = '0;
            end
            length_copy = '0;
            pending_results.delete();
            results_seen   = 0;
            mismatch_count = 0;
            outstanding   <= 0;
        end
        else
        begin
            // a result transfer always belongs to an earlier item
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                              m_tuser[0], m_tdata[IDX_W-1:0]));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser[0] !== want.found)
                    begin
                        report_mismatch($sformatf("found is %0b, expected %0b",
                                                  m_tuser[0], want.found));
                    end
                    if (m_tdata[IDX_W-1:0] !== want.position)
                    begin
                        report_mismatch($sformatf("position is %0d, expected %0d",
                                                  m_tdata[IDX_W-1:0], want.position));
                    end
                end
                results_seen = results_seen + 1;
            end

            // register write
            if (cfg_valid && cfg_ready)
            begin
                length_copy = cfg_data;
            end

            // item transfer
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    MODE_LOAD:   entries[s_tdata[3:0]] = s_tdata[35:4];
                    MODE_LINEAR: pending_results.push_back(scan_and_swap(s_tdata[35:4]));
                    MODE_BINARY: pending_results.push_back(halving_search(s_tdata[35:4]));
                    default:     ;
                endcase
            end

            outstanding <= pending_results.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives loads, linear and binary searches into the table search engine with
// bursty input and a stalling result side, changes table_length between
// phases while the engine is idle, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
    import tse_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int TARGET_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [39:0]      s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;
    logic [0:0]       m_tuser;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;
    int items_sent;
    int burst_left;
    int active_len;
    int hold_requests;
    int holds_done;

    // values last loaded per index, used only to aim search keys
    logic signed [ENTRY_WIDTH-1:0] loaded_val [TABLE_DEPTH];

    table_search_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    search_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: stall segments, plus long hold-offs on request
    initial
    begin : result_sink
        int seg_len;
        int style;
        holds_done = 0;
        m_tready   = 1'b0;
        @(posedge clk);
        forever
        begin
            if (holds_done != hold_requests)
            begin
                holds_done = holds_done + 1;
                m_tready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                style   = $urandom_range(0, 3);
                seg_len = $urandom_range(1, 40);
                repeat (seg_len)
                begin
                    case (style)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 7) == 0);
                        default: m_tready <= 1'b0;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // offer one item and hold it until the transfer; gaps between bursts
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                             input logic signed [ENTRY_WIDTH-1:0] key);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0000, key, idx};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent = items_sent + 1;
        if (mode == MODE_LOAD)
        begin
            loaded_val[idx] = key;
        end
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
        end
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 7);
        end
    endtask

    // stop offering, wait for every expected result, then let a load finish
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // table_length write while idle
    task automatic write_length(input logic [CFG_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        active_len = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
    endtask

    // search key: mostly a table value or a near miss, sometimes anything
    function automatic logic signed [ENTRY_WIDTH-1:0] pick_key();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (active_len == 0 || r >= 85)
        begin
            return $urandom;
        end
        k = $urandom_range(0, active_len - 1);
        if (r < 70)
        begin
            return loaded_val[k];
        end
        if (r < 78)
        begin
            return loaded_val[k] + 1;
        end
        return loaded_val[k] - 1;
    endfunction

    // fill the searched range with ascending values, narrow ones give duplicates
    task automatic load_sorted(input int count);
        logic signed [ENTRY_WIDTH-1:0] vals [TABLE_DEPTH];
        logic signed [ENTRY_WIDTH-1:0] tmp;
        bit                            narrow;
        int                            j;
        narrow = $urandom_range(0, 1);
        for (int i = 0; i < count; i++)
        begin
            vals[i] = narrow ? ($urandom_range(0, 16) - 8) : $urandom;
        end
        for (int i = 1; i < count; i++)
        begin
            tmp = vals[i];
            j   = i - 1;
            while (j >= 0 && vals[j] > tmp)
            begin
                vals[j + 1] = vals[j];
                j = j - 1;
            end
            vals[j + 1] = tmp;
        end
        for (int i = 0; i < count; i++)
        begin
            send_item(MODE_LOAD, i[INDEX_W-1:0], vals[i]);
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        logic signed [ENTRY_WIDTH-1:0] sorted_vals [TABLE_DEPTH];
        logic [CFG_W-1:0]              len_value;
        int                            phase;
        int                            r;
        int                            n_items;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        items_sent    = 0;
        burst_left    = 0;
        active_len    = 0;
        hold_requests = 0;
        sorted_vals = '{32'sh8000_0000, -32'sd100000, -32'sd5000, -32'sd7, -32'sd1,
                        32'sd0, 32'sd0, 32'sd3, 32'sd42, 32'sd100, 32'sd977,
                        32'sd65536, 32'sd1000000, 32'sh1234_5678, 32'sh7FFF_FFFE,
                        32'sh7FFF_FFFF};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length: nothing is read, both searches miss; unused mode ignored
        write_length(5'd0);
        send_item(MODE_LINEAR, 4'd0, 32'sd0);
        send_item(MODE_BINARY, 4'd15, -32'sd1);
        send_item(MODE_UNUSED, 4'd15, 32'shFFFF_FFFF);

        // every entry written once, sorted, extremes at both ends
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            send_item(MODE_LOAD, i[INDEX_W-1:0], sorted_vals[i]);
        end

        // full table: binary hits at both ends, duplicate, miss;
        // linear hit at the far end with swap, linear miss,
        // then binary over the now unsorted table
        write_length(5'd16);
        send_item(MODE_BINARY, 4'd0, 32'sh8000_0000);
        send_item(MODE_BINARY, 4'd0, 32'sh7FFF_FFFF);
        send_item(MODE_BINARY, 4'd0, 32'sd0);
        send_item(MODE_BINARY, 4'd0, 32'sd4);
        send_item(MODE_LINEAR, 4'd0, 32'sh7FFF_FFFF);
        send_item(MODE_LINEAR, 4'd0, 32'sd5);
        send_item(MODE_BINARY, 4'd0, 32'sh8000_0000);
        send_item(MODE_UNUSED, 4'd0, 32'sd0);

        // random phases, each with its own table_length
        phase = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       len_value = 5'd0;
                1:       len_value = 5'd1;
                2:       len_value = 5'd16;
                3:       len_value = 5'd31;
                4:       len_value = CFG_W'($urandom_range(17, 31));
                default: len_value = CFG_W'($urandom_range(2, 15));
            endcase
            write_length(len_value);
            if ($urandom_range(0, 3) != 0)
            begin
                load_sorted(active_len);
            end
            // long result hold-off while items keep coming
            if (phase == 3 || phase == 30)
            begin
                hold_requests = hold_requests + 1;
            end
            n_items = $urandom_range(10, 40);
            repeat (n_items)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    send_item(MODE_BINARY, INDEX_W'($urandom_range(0, 15)), pick_key());
                end
                else if (r < 85)
                begin
                    send_item(MODE_LINEAR, INDEX_W'($urandom_range(0, 15)), pick_key());
                end
                else if (r < 94)
                begin
                    send_item(MODE_LOAD, INDEX_W'($urandom_range(0, 15)), $urandom);
                end
                else
                begin
                    send_item(MODE_UNUSED, INDEX_W'($urandom_range(0, 15)), $urandom);
                end
            end
            phase = phase + 1;
        end

        drain();
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/tse_pkg.sv
hdl/table_search_engine.sv
tb/search_checker.sv
tb/testbench.sv
